/* sv/afc_pkg.sv */
`default_nettype none

package afc_pkg;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int TERM_W     = PROD_W + 1;
    localparam int SUM_W      = TERM_W + 2;
    localparam int NUM_AXES   = 3;
    localparam int NUM_ROWS   = 4;
    localparam int NUM_PLANES = 6;
    localparam int NUM_ENTRIES = NUM_ROWS * NUM_ROWS;
    localparam int NUM_PAIRS  = NUM_ENTRIES / 2;
    localparam int PAIR_W     = $clog2(NUM_PAIRS);
    localparam int CFG_IDX_W  = PAIR_W + 1;
    localparam int CFG_DATA_W = 2 * COORD_W;

    localparam logic [2:0] PL_LEFT   = 3'd0;
    localparam logic [2:0] PL_RIGHT  = 3'd1;
    localparam logic [2:0] PL_BOTTOM = 3'd2;
    localparam logic [2:0] PL_TOP    = 3'd3;
    localparam logic [2:0] PL_NEAR   = 3'd4;
    localparam logic [2:0] PL_FAR    = 3'd5;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic signed [SUM_W-1:0]   t_sum;

    typedef struct packed {
        logic valid;
        logic outside;
    } t_plane_res;

    // Plane value as a combination of the clip-space rows x, y, z and w.
    function automatic t_term plane_comb(input logic [2:0] pl, input t_prod a0,
                                         input t_prod a1, input t_prod a2,
                                         input t_prod a3);
        t_term x0;
        t_term x1;
        t_term x2;
        t_term x3;
        t_term res;
        x0 = {a0[PROD_W-1], a0};
        x1 = {a1[PROD_W-1], a1};
        x2 = {a2[PROD_W-1], a2};
        x3 = {a3[PROD_W-1], a3};
        unique case (pl)
            PL_LEFT:   res = x0 + x3;
            PL_RIGHT:  res = x0 - x3;
            PL_BOTTOM: res = x1 + x3;
            PL_TOP:    res = x1 - x3;
            PL_NEAR:   res = x2;
            PL_FAR:    res = x2 - x3;
            default:   res = '0;
        endcase
        return res;
    endfunction

    // Planes whose outside side is a positive value take the minimum over corners.
    function automatic logic plane_is_pos(input logic [2:0] pl);
        return (pl == PL_RIGHT) || (pl == PL_TOP) || (pl == PL_FAR);
    endfunction

endpackage

`default_nettype wire

/* sv/afc_plane_unit.sv */
`default_nettype none

module afc_plane_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          i_pos_test,
    input  wire afc_pkg::t_term                i_lo [afc_pkg::NUM_AXES],
    input  wire afc_pkg::t_term                i_hi [afc_pkg::NUM_AXES],
    input  wire afc_pkg::t_sum                 i_const,
    output afc_pkg::t_plane_res                o_res
);
    import afc_pkg::*;

    logic  r_sel_valid;
    t_term r_sel [NUM_AXES];
    logic  r_out_valid;
    logic  r_outside;
    t_sum  n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_sel_valid <= i_valid;
            r_out_valid <= r_sel_valid;
        end
    end

    // The box is outside when even its most favorable corner is outside, and
    // that corner is picked one axis at a time.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_AXES; k++) begin
            if (i_pos_test) begin
                r_sel[k] <= (i_lo[k] < i_hi[k]) ? i_lo[k] : i_hi[k];
            end else begin
                r_sel[k] <= (i_lo[k] > i_hi[k]) ? i_lo[k] : i_hi[k];
            end
        end
    end

    always_comb begin
        n_sum = SUM_W'(r_sel[0]) + SUM_W'(r_sel[1]) + SUM_W'(r_sel[2]) + i_const;
    end

    always_ff @(posedge i_clk) begin
        if (i_pos_test) begin
            r_outside <= !n_sum[SUM_W-1] && (n_sum != '0);
        end else begin
            r_outside <= n_sum[SUM_W-1];
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.outside = r_outside;

endmodule

`default_nettype wire

/* sv/aabb_frustum_cull.sv */
// Culls one axis-aligned box per clock, while o_busy is low, against the view
// frustum of the configured view-projection matrix. A box is taken whenever
// i_start is high and o_busy is low, and its verdict appears on o_visible with a
// one-cycle o_done strobe, in order, after the pipeline of corner products,
// plane combination, corner selection and plane sums; a new box may follow in
// every cycle. The receiver cannot stall the block.
// o_busy is high only during reset and the cycle after it. Write the matrix
// through the configuration port only while no box is in flight.
`default_nettype none

module aabb_frustum_cull #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire afc_pkg::t_coord                 i_box_min_x,
    input  wire afc_pkg::t_coord                 i_box_min_y,
    input  wire afc_pkg::t_coord                 i_box_min_z,
    input  wire afc_pkg::t_coord                 i_box_max_x,
    input  wire afc_pkg::t_coord                 i_box_max_y,
    input  wire afc_pkg::t_coord                 i_box_max_z,
    output logic                                 o_done,
    output logic                                 o_visible,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [afc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [afc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import afc_pkg::*;

    logic       r_busy;
    t_coord     r_mat [NUM_ENTRIES];
    logic       r_v0;
    t_coord     r_lo [NUM_AXES];
    t_coord     r_hi [NUM_AXES];
    logic       r_v1;
    t_prod      r_prod_lo [NUM_ROWS][NUM_AXES];
    t_prod      r_prod_hi [NUM_ROWS][NUM_AXES];
    logic       r_v2;
    t_term      r_term_lo [NUM_PLANES][NUM_AXES];
    t_term      r_term_hi [NUM_PLANES][NUM_AXES];
    t_sum       n_const [NUM_PLANES];
    t_plane_res w_res [NUM_PLANES];
    logic [NUM_PLANES-1:0] w_res_valid;
    logic [NUM_PLANES-1:0] w_outside;
    logic       r_done;
    logic       r_visible;
    logic       n_accept;
    logic       n_cfg_write;

    assign n_accept    = i_start && !r_busy;
    assign n_cfg_write = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_mat[i] <= '0;
            end
        end else if (n_cfg_write && (i_cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
            r_mat[{i_cfg_index[PAIR_W-1:0], 1'b0}] <= i_cfg_data[COORD_W-1:0];
            r_mat[{i_cfg_index[PAIR_W-1:0], 1'b1}] <= i_cfg_data[CFG_DATA_W-1:COORD_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v0   <= n_accept;
            r_v1   <= r_v0;
            r_v2   <= r_v1;
            r_done <= w_res[0].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo[0] <= i_box_min_x;
        r_lo[1] <= i_box_min_y;
        r_lo[2] <= i_box_min_z;
        r_hi[0] <= i_box_max_x;
        r_hi[1] <= i_box_max_y;
        r_hi[2] <= i_box_max_z;
    end

    // Column k of the matrix scales axis k; row r is the clip coordinate.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prod_lo[r][k] <= t_prod'(r_lo[k]) * t_prod'(r_mat[k * NUM_ROWS + r]);
                r_prod_hi[r][k] <= t_prod'(r_hi[k]) * t_prod'(r_mat[k * NUM_ROWS + r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_term_lo[p][k] <= plane_comb(3'(p), r_prod_lo[0][k], r_prod_lo[1][k],
                                              r_prod_lo[2][k], r_prod_lo[3][k]);
                r_term_hi[p][k] <= plane_comb(3'(p), r_prod_hi[0][k], r_prod_hi[1][k],
                                              r_prod_hi[2][k], r_prod_hi[3][k]);
            end
        end
    end

    // The translation column enters with w equal to one in the product scale.
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            n_const[p] = SUM_W'(plane_comb(3'(p),
                             t_prod'(r_mat[3 * NUM_ROWS + 0]),
                             t_prod'(r_mat[3 * NUM_ROWS + 1]),
                             t_prod'(r_mat[3 * NUM_ROWS + 2]),
                             t_prod'(r_mat[3 * NUM_ROWS + 3]))) <<< FRAC_BITS;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        afc_plane_unit u_plane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_valid    (r_v2),
            .i_pos_test (plane_is_pos(3'(p))),
            .i_lo       (r_term_lo[p]),
            .i_hi       (r_term_hi[p]),
            .i_const    (n_const[p]),
            .o_res      (w_res[p])
        );
        assign w_res_valid[p] = w_res[p].valid;
        assign w_outside[p]   = w_res[p].outside;
    end

    always_ff @(posedge i_clk) begin
        r_visible <= !(|w_outside);
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_done      = r_done;
    assign o_visible   = r_visible;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 |-> ##5 o_done)
        else $error("Accepted beat did not produce a result after five cycles.");

    a_plane_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid == {NUM_PLANES{1'b0}}) || (w_res_valid == {NUM_PLANES{1'b1}}))
        else $error("Plane units are out of step.");

    a_no_take_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_busy) |-> !r_v0)
        else $error("A beat was taken while busy.");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_v2, 3))
        else $error("Result strobe without a box in the pipeline.");

endmodule

`default_nettype wire

/* sim/aabb_frustum_cull_tb.sv */
`timescale 1ns / 100ps

module aabb_frustum_cull_tb;
    import afc_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int ONE = 1 << FRAC_BITS;
    localparam int BOXES_PER_PHASE = 125;

    typedef struct {
        t_coord min_x;
        t_coord min_y;
        t_coord min_z;
        t_coord max_x;
        t_coord max_y;
        t_coord max_z;
    } t_box;

    typedef enum {MAT_NEAR, MAT_PERSP, MAT_RANDOM, MAT_EXTREME} t_mat_kind;

    class t_cull_scoreboard;
        t_coord entry [NUM_ENTRIES];
        bit verdicts_due [$];
        int boxes_seen;
        int culled_seen;
        int mismatches;

        function new();
            foreach (entry[i]) entry[i] = '0;
            boxes_seen = 0;
            culled_seen = 0;
            mismatches = 0;
        endfunction

        function void write_pair(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx < NUM_PAIRS) begin
                entry[2*idx]     = data[COORD_W-1:0];
                entry[2*idx + 1] = data[CFG_DATA_W-1:COORD_W];
            end
        endfunction

        // Exact clip-space test of all eight corners against the six planes.
        function bit box_visible(t_box b);
            t_coord v [NUM_AXES];
            logic signed [127:0] p [NUM_ROWS];
            int hits [NUM_PLANES];
            bit culled;
            culled = 1'b0;
            foreach (hits[k]) hits[k] = 0;
            for (int c = 0; c < 8; c++) begin
                v[0] = (c & 1) ? b.max_x : b.min_x;
                v[1] = (c & 2) ? b.max_y : b.min_y;
                v[2] = (c & 4) ? b.max_z : b.min_z;
                for (int r = 0; r < NUM_ROWS; r++) begin
                    p[r] = entry[12 + r];
                    p[r] = p[r] <<< FRAC_BITS;
                    for (int k = 0; k < NUM_AXES; k++)
                        p[r] = p[r] + entry[4*k + r] * v[k];
                end
                if (p[0] + p[3] < 0) hits[PL_LEFT]++;
                if (p[0] - p[3] > 0) hits[PL_RIGHT]++;
                if (p[1] + p[3] < 0) hits[PL_BOTTOM]++;
                if (p[1] - p[3] > 0) hits[PL_TOP]++;
                if (p[2] < 0) hits[PL_NEAR]++;
                if (p[2] - p[3] > 0) hits[PL_FAR]++;
            end
            foreach (hits[k]) if (hits[k] == 8) culled = 1'b1;
            return !culled;
        endfunction

        function void note_box(t_box b);
            bit vis;
            vis = box_visible(b);
            verdicts_due = {verdicts_due, vis};
            boxes_seen++;
            if (!vis) culled_seen++;
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual visible=%0b", $time, got);
                mismatches++;
            end else begin
                want = verdicts_due.pop_front();
                if (got !== want) begin
                    $display("%0t: visible mismatch, expected %0b, actual %0b", $time, want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_start;
    logic o_busy;
    t_coord i_box_min_x;
    t_coord i_box_min_y;
    t_coord i_box_min_z;
    t_coord i_box_max_x;
    t_coord i_box_max_y;
    t_coord i_box_max_z;
    logic o_done;
    logic o_visible;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    t_cull_scoreboard sb;
    t_coord plan [NUM_ENTRIES];
    int settings_loaded = 0;

    aabb_frustum_cull #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_verdict(o_visible);
    end

    function automatic int srand(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic t_coord pick_edge();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4: return ONE;
            5: return -ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_box box6(int nx, int ny, int nz, int xx, int xy, int xz);
        t_box b;
        b.min_x = nx; b.min_y = ny; b.min_z = nz;
        b.max_x = xx; b.max_y = xy; b.max_z = xz;
        return b;
    endfunction

    function automatic t_box rand_box();
        int sel;
        int ctr;
        int half;
        t_coord lo [NUM_AXES];
        t_coord hi [NUM_AXES];
        sel = $urandom_range(0, 99);
        for (int k = 0; k < NUM_AXES; k++) begin
            if (sel < 10) begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end else if (sel < 15) begin
                lo[k] = pick_edge();
                hi[k] = pick_edge();
            end else begin
                ctr = srand(8 * ONE);
                half = $urandom_range(0, 2 * ONE);
                lo[k] = ctr - half;
                hi[k] = ctr + half;
                if ($urandom_range(0, 19) == 0) begin
                    lo[k] = ctr + half;
                    hi[k] = ctr - half;
                end
            end
        end
        return box6(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic drive_fields(t_box b);
        i_box_min_x = b.min_x;
        i_box_min_y = b.min_y;
        i_box_min_z = b.min_z;
        i_box_max_x = b.max_x;
        i_box_max_y = b.max_y;
        i_box_max_z = b.max_z;
    endtask

    task automatic send_box(t_box b);
        @(negedge i_clk);
        i_start = 1'b1;
        drive_fields(b);
        do @(posedge i_clk); while (o_busy);
        sb.note_box(b);
    endtask

    task automatic pause_sender(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_start = 1'b0;
            drive_fields(rand_box());
        end
    endtask

    task automatic wait_results();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_pair(idx, data);
    endtask

    // Writes the planned matrix once the pipeline is empty, with optional
    // writes to indexes past the last pair mixed in.
    task automatic load_plan(bit stray);
        wait_results();
        repeat (8) @(posedge i_clk);
        for (int k = 0; k < NUM_PAIRS; k++) begin
            if (stray && $urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(NUM_PAIRS, 2 * NUM_PAIRS - 1)),
                          {$urandom, $urandom});
            write_reg(CFG_IDX_W'(k), {plan[2*k + 1], plan[2*k]});
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        settings_loaded++;
    endtask

    task automatic make_plan(t_mat_kind kind);
        int row;
        int col;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            row = i % 4;
            col = i / 4;
            case (kind)
                MAT_RANDOM:  plan[i] = $urandom;
                MAT_EXTREME: plan[i] = pick_edge();
                default: begin
                    if (col == 3 && row < 3) plan[i] = srand(ONE);
                    else if (row == 3) plan[i] = (col == 3) ? $urandom_range(ONE / 2, 2 * ONE)
                                                            : srand(ONE / 16);
                    else if (row == col) plan[i] = $urandom_range(ONE / 4, 2 * ONE);
                    else plan[i] = srand(ONE / 4);
                end
            endcase
        end
        if (kind == MAT_PERSP) begin
            plan[11] = -ONE;
            plan[14] = srand(ONE);
            plan[15] = srand(ONE / 4);
        end
    endtask

    task automatic send_extremes();
        send_box(box6(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_box(box6(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_box(box6(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    endtask

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_mat_kind kinds [8];
        int gap_pct;
        kinds = '{MAT_NEAR, MAT_PERSP, MAT_RANDOM, MAT_NEAR,
                  MAT_EXTREME, MAT_PERSP, MAT_RANDOM, MAT_NEAR};
        sb = new();
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        drive_fields(box6(0, 0, 0, 0, 0, 0));
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Matrix is zero after reset; out-of-range writes must leave it so.
        write_reg(CFG_IDX_W'(NUM_PAIRS), {$urandom, $urandom});
        write_reg(CFG_IDX_W'(2 * NUM_PAIRS - 1), {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        send_extremes();

        foreach (plan[i]) plan[i] = '0;
        foreach (plan[i]) if (i % 5 == 0) plan[i] = ONE;
        load_plan(1'b0);
        send_box(box6(-ONE/2, -ONE/2, ONE/4, ONE/2, ONE/2, 3*ONE/4));
        send_box(box6(-3*ONE, -ONE/2, ONE/4, -2*ONE, ONE/2, 3*ONE/4));
        send_box(box6(2*ONE, -ONE/2, ONE/4, 3*ONE, ONE/2, 3*ONE/4));
        send_box(box6(-ONE/2, -3*ONE, ONE/4, ONE/2, -2*ONE, 3*ONE/4));
        send_box(box6(-ONE/2, 2*ONE, ONE/4, ONE/2, 3*ONE, 3*ONE/4));
        send_box(box6(-ONE/2, -ONE/2, -2*ONE, ONE/2, ONE/2, -ONE));
        send_box(box6(-ONE/2, -ONE/2, 2*ONE, ONE/2, ONE/2, 3*ONE));
        send_box(box6(-3*ONE, -ONE/2, ONE/4, 3*ONE, ONE/2, 3*ONE/4));
        send_box(box6(ONE, -ONE/2, ONE/4, 2*ONE, ONE/2, 3*ONE/4));
        send_box(box6(ONE + 1, -ONE/2, ONE/4, 2*ONE, ONE/2, 3*ONE/4));
        send_box(box6(3*ONE, -ONE/2, ONE/4, 2*ONE, ONE/2, 3*ONE/4));
        send_box(box6(ONE/2, -ONE/2, ONE/4, -ONE/2, ONE/2, 3*ONE/4));
        send_extremes();

        foreach (plan[i]) plan[i] = 32'h7FFF_FFFF;
        load_plan(1'b0);
        send_extremes();
        foreach (plan[i]) plan[i] = 32'h8000_0000;
        load_plan(1'b1);
        send_extremes();

        foreach (kinds[ph]) begin
            make_plan(kinds[ph]);
            load_plan(1'b1);
            gap_pct = (ph == $size(kinds) - 1) ? 0 : 10 * $urandom_range(0, 3);
            for (int n = 0; n < BOXES_PER_PHASE; n++) begin
                if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
                    pause_sender($urandom_range(1, 16));
                if (n == BOXES_PER_PHASE / 2 && gap_pct != 0) wait_results();
                send_box(rand_box());
            end
        end

        wait_results();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d boxes, %0d of them culled, under %0d matrix settings.",
                 sb.boxes_seen, sb.culled_seen, settings_loaded);
        $display("Covered zero, identity, extreme, perspective and random matrices, %s",
                 "ignored register indexes, swapped corners and input-side idle bursts.");
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
